/* sv/mrks_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mrks_pkg;

  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_ETX = 8'h03;

  localparam int NUM_KW_A = 4;
  localparam int NUM_KW_B = 6;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_OK         = 4'd1,
    EV_CONNECT    = 4'd2,
    EV_ERROR      = 4'd3,
    EV_NO_CARRIER = 4'd4,
    EV_RINGBACK   = 4'd5,
    EV_BUSY       = 4'd6,
    EV_DLE_ETX    = 4'd7,
    EV_DATA_BYTE  = 4'd8
  } event_e;

  typedef enum logic [2:0] {
    KW_OK,
    KW_WIND,
    KW_CONNECT,
    KW_ERROR,
    KW_CARRIER,
    KW_BUSY
  } kw_e;

  // One byte as it moves from the input register into the matchers.
  typedef struct packed {
    logic       side;
    logic       data_mode;
    logic [7:0] chr;
  } step_t;

  typedef struct packed {
    logic   hit;
    event_e ev;
  } kw_res_t;

  typedef struct packed {
    logic       done;
    logic [2:0] pos;
  } kw_adv_t;

  localparam kw_e SIDE_A_KW [NUM_KW_A] = '{KW_OK, KW_CONNECT, KW_ERROR, KW_CARRIER};
  localparam kw_e SIDE_B_KW [NUM_KW_B] =
    '{KW_OK, KW_WIND, KW_CONNECT, KW_ERROR, KW_CARRIER, KW_BUSY};

  // Keyword text is right-justified: the last character sits in bits 7:0.
  function automatic logic [55:0] kw_text(kw_e kw);
    logic [55:0] t;
    case (kw)
      KW_OK:      t = 56'("OK");
      KW_WIND:    t = 56'("+WIND: ");
      KW_CONNECT: t = 56'("NNECT\r");
      KW_ERROR:   t = 56'("RROR");
      KW_CARRIER: t = 56'("CARRIER");
      KW_BUSY:    t = 56'("BUSY");
      default:    t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(kw_e kw);
    logic [2:0] l;
    case (kw)
      KW_OK:      l = 3'd2;
      KW_WIND:    l = 3'd7;
      KW_CONNECT: l = 3'd6;
      KW_ERROR:   l = 3'd4;
      KW_CARRIER: l = 3'd7;
      KW_BUSY:    l = 3'd4;
      default:    l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic event_e kw_event(kw_e kw);
    event_e e;
    case (kw)
      KW_OK:      e = EV_OK;
      KW_WIND:    e = EV_RINGBACK;
      KW_CONNECT: e = EV_CONNECT;
      KW_ERROR:   e = EV_ERROR;
      KW_CARRIER: e = EV_NO_CARRIER;
      KW_BUSY:    e = EV_BUSY;
      default:    e = EV_NONE;
    endcase
    return e;
  endfunction

  // Character p of the keyword; p must be below the keyword length.
  function automatic logic [7:0] kw_char(kw_e kw, logic [2:0] p);
    logic [2:0]  k;
    logic [55:0] s;
    k = kw_len(kw) - 3'd1 - p;
    s = kw_text(kw) >> {k, 3'b000};
    return s[7:0];
  endfunction

  function automatic logic [7:0] fold_upper(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // A mismatch drops the position to zero without retrying the first character.
  function automatic kw_adv_t kw_advance(kw_e kw, logic [2:0] pos, logic [7:0] c);
    kw_adv_t    r;
    logic [2:0] cur;
    logic [2:0] nxt;
    cur = (pos >= kw_len(kw)) ? 3'd0 : pos;
    nxt = (kw_char(kw, cur) == c) ? cur + 3'd1 : 3'd0;
    r.done = (nxt >= kw_len(kw));
    r.pos  = r.done ? 3'd0 : nxt;
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/mrks_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mrks_in_if;
  logic       valid;
  logic       ready;
  logic       side;
  logic [7:0] byte_in;
  logic       data_mode;

  modport source (output valid, output side, output byte_in, output data_mode,
                  input ready);
  modport sink (input valid, input side, input byte_in, input data_mode,
                output ready);
endinterface

interface mrks_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] data_byte;

  modport source (output valid, output event_res, output data_byte, input ready);
  modport sink (input valid, input event_res, input data_byte, output ready);
endinterface

`default_nettype wire

/* sv/mrks_keyword_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrks_keyword_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             commit_i,
  input  wire mrks_pkg::step_t  step_i,
  output mrks_pkg::kw_res_t     res_o
);
  import mrks_pkg::*;

  logic [2:0] side_a_pos_q [NUM_KW_A];
  logic [2:0] side_a_pos_d [NUM_KW_A];
  logic [2:0] side_b_pos_q [NUM_KW_B];
  logic [2:0] side_b_pos_d [NUM_KW_B];

  logic [7:0] upper;
  kw_adv_t    adv_a [NUM_KW_A];
  kw_adv_t    adv_b [NUM_KW_B];

  assign upper = fold_upper(step_i.chr);

  always_comb begin
    for (int i = 0; i < NUM_KW_A; i++) begin
      adv_a[i] = kw_advance(SIDE_A_KW[i], side_a_pos_q[i], upper);
    end
    for (int i = 0; i < NUM_KW_B; i++) begin
      adv_b[i] = kw_advance(SIDE_B_KW[i], side_b_pos_q[i], upper);
    end
  end

  // Matchers run in priority order; the ones after the first hit keep their position.
  always_comb begin
    side_a_pos_d = side_a_pos_q;
    side_b_pos_d = side_b_pos_q;
    res_o.hit    = 1'b0;
    res_o.ev     = EV_NONE;
    if (!step_i.data_mode) begin
      if (!step_i.side) begin
        for (int i = 0; i < NUM_KW_A; i++) begin
          if (!res_o.hit) begin
            side_a_pos_d[i] = adv_a[i].pos;
            if (adv_a[i].done) begin
              res_o.hit = 1'b1;
              res_o.ev  = kw_event(SIDE_A_KW[i]);
            end
          end
        end
      end else begin
        for (int i = 0; i < NUM_KW_B; i++) begin
          if (!res_o.hit) begin
            side_b_pos_d[i] = adv_b[i].pos;
            if (adv_b[i].done) begin
              res_o.hit = 1'b1;
              res_o.ev  = kw_event(SIDE_B_KW[i]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KW_A; i++) begin
        side_a_pos_q[i] <= 3'd0;
      end
      for (int i = 0; i < NUM_KW_B; i++) begin
        side_b_pos_q[i] <= 3'd0;
      end
    end else if (commit_i) begin
      side_a_pos_q <= side_a_pos_d;
      side_b_pos_q <= side_b_pos_d;
    end
  end

endmodule

`default_nettype wire

/* sv/mrks_dle_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrks_dle_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        commit_i,
  input  wire logic        kw_hit_i,
  input  wire mrks_pkg::step_t step_i,
  output mrks_pkg::event_e ev_o,
  output logic [7:0]       data_o
);
  import mrks_pkg::*;

  logic [7:0] side_a_prev_q, side_a_prev_d;
  logic [7:0] side_b_prev_q, side_b_prev_d;
  logic [7:0] prev;
  logic [7:0] hist;

  assign prev = step_i.side ? side_b_prev_q : side_a_prev_q;

  always_comb begin
    side_a_prev_d = side_a_prev_q;
    side_b_prev_d = side_b_prev_q;
    ev_o          = EV_NONE;
    data_o        = 8'd0;
    // The second DLE of a stuffed pair is remembered as zero so a third one stands alone.
    hist = (prev == CH_DLE && step_i.chr == CH_DLE) ? 8'd0 : step_i.chr;
    if (prev == CH_DLE && step_i.chr == CH_ETX) begin
      ev_o = EV_DLE_ETX;
      // Side B keeps its DLE, so a further ETX reports again.
      if (!step_i.side) begin
        side_a_prev_d = 8'd0;
      end
    end else begin
      if (step_i.data_mode) begin
        ev_o   = EV_DATA_BYTE;
        data_o = step_i.chr;
      end
      if (step_i.side) begin
        side_b_prev_d = hist;
      end else begin
        side_a_prev_d = hist;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_prev_q <= 8'd0;
      side_b_prev_q <= 8'd0;
    end else if (commit_i && !kw_hit_i) begin
      side_a_prev_q <= side_a_prev_d;
      side_b_prev_q <= side_b_prev_d;
    end
  end

endmodule

`default_nettype wire

/* sv/modem_response_keyword_spotter.sv */
// Modem response keyword spotter.
//
// in_i carries one modem character per transfer together with the stream it
// came from (side) and the data-mode flag. out_o returns exactly one result
// per input transfer, in order: an event code and, for data bytes, the byte.
// In command mode the character is matched against the response keywords of
// its side; in either mode DLE-ETX is detected and data bytes are forwarded.
//
// A byte taken from in_i is held in the input register, moves into the result
// register when out_o is not stalled, and leaves from there when out_o takes it.
// Throughput is one byte per cycle while out_o is not stalled: the input
// register and the result register form a two-stage pipeline, and the keyword
// and history state advances as a byte moves into the result register.
//
// When the receiver stalls, the result register holds and the input register
// keeps one more byte, after which in_i.ready drops. Reset clears the match
// positions, the DLE history of both sides and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module modem_response_keyword_spotter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mrks_in_if.sink     in_i,
  mrks_out_if.source  out_o
);
  import mrks_pkg::*;

  logic       in_valid_q;
  step_t      in_q;
  logic       out_valid_q;
  event_e     ev_q, ev_d;
  logic [7:0] data_q, data_d;
  logic       advance;

  kw_res_t    kw_res;
  event_e     dle_ev;
  logic [7:0] dle_data;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.side      <= in_i.side;
      in_q.data_mode <= in_i.data_mode;
      in_q.chr       <= in_i.byte_in;
    end
  end

  mrks_keyword_unit u_keyword (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .step_i   (in_q),
    .res_o    (kw_res)
  );

  mrks_dle_unit u_dle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .kw_hit_i (kw_res.hit),
    .step_i   (in_q),
    .ev_o     (dle_ev),
    .data_o   (dle_data)
  );

  assign ev_d   = kw_res.hit ? kw_res.ev : dle_ev;
  assign data_d = kw_res.hit ? 8'd0 : dle_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q   <= ev_d;
      data_q <= data_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = ev_q;
  assign out_o.data_byte = data_q;

`ifndef SYNTH
  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register did not load on transfer from input stage");

  a_held_input_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled input stage lost or changed its byte");

  a_data_only_for_data_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q != EV_DATA_BYTE) |-> (data_q == 8'd0))
    else $error("data byte set for an event that is not a data byte");

  a_kw_hit_not_in_data_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_q.data_mode) |-> !kw_res.hit)
    else $error("keyword reported while in data mode");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mrks_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    event_e     ev;
    logic [7:0] data;
  } spot_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mrks_in_if  in_if ();
  mrks_out_if out_if ();

  modem_response_keyword_spotter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Keyword tables of the two streams in match priority order; side A uses
  // only the first four slots.
  string  words     [2][6] = '{'{"OK", "NNECT\015", "RROR", "CARRIER", "", ""},
                               '{"OK", "+WIND: ", "NNECT\015", "RROR", "CARRIER", "BUSY"}};
  event_e word_event [2][6] = '{'{EV_OK, EV_CONNECT, EV_ERROR, EV_NO_CARRIER, EV_NONE, EV_NONE},
                               '{EV_OK, EV_RINGBACK, EV_CONNECT, EV_ERROR, EV_NO_CARRIER,
                                 EV_BUSY}};
  int     word_count [2] = '{4, 6};

  logic [2:0] match_pos [2][6];
  logic [7:0] last_byte [2];

  spot_result_t expected_events [$];
  int errors      = 0;
  int sent_count  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit tx_idle_en  = 1'b1;
  bit rx_stall_en = 1'b1;

  function automatic spot_result_t predict_event(logic side, logic [7:0] chr, logic dm);
    spot_result_t r;
    logic [7:0]   up;
    logic [2:0]   p;
    logic         hit;
    string        w;
    int           i;
    r.ev   = EV_NONE;
    r.data = 8'h00;
    hit    = 1'b0;
    if (!dm) begin
      up = (chr >= 8'h61 && chr <= 8'h7a) ? chr - 8'd32 : chr;
      for (i = 0; i < word_count[side] && !hit; i++) begin
        w = words[side][i];
        p = match_pos[side][i];
        if (p >= w.len()) p = 3'd0;
        // A mismatch drops to zero; the byte is not retried as a first character.
        if (8'(w[p]) == up) p = p + 3'd1;
        else p = 3'd0;
        if (p >= w.len()) begin
          match_pos[side][i] = 3'd0;
          r.ev = word_event[side][i];
          hit  = 1'b1;
        end else begin
          match_pos[side][i] = p;
        end
      end
    end
    if (hit) return r;
    if (last_byte[side] == CH_DLE && chr == CH_ETX) begin
      r.ev = EV_DLE_ETX;
      // Only side A forgets the DLE; side B keeps it and pairs with a further ETX.
      if (!side) last_byte[side] = 8'h00;
      return r;
    end
    if (dm) begin
      r.ev   = EV_DATA_BYTE;
      r.data = chr;
    end
    last_byte[side] = (last_byte[side] == CH_DLE && chr == CH_DLE) ? 8'h00 : chr;
    return r;
  endfunction

  // Called at a falling edge and returns at a falling edge.
  task automatic send_byte(input logic side, input logic [7:0] chr, input logic dm);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.side      <= side;
    in_if.byte_in   <= chr;
    in_if.data_mode <= dm;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_events.push_back(predict_event(side, chr, dm));
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input logic side, input string s, input logic dm);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(side, 8'(s[i]), dm);
  endtask

  // Sends a keyword of either table in random letter case, sometimes cut short.
  task automatic send_keyword(input logic side, input bit truncate);
    string      w;
    logic       from;
    logic [7:0] c;
    int         n;
    int         i;
    from = ($urandom_range(0, 4) == 0) ? ~side : side;
    w = words[from][$urandom_range(0, word_count[from] - 1)];
    n = truncate ? $urandom_range(1, w.len()) - 1 : w.len();
    for (i = 0; i < n; i++) begin
      c = 8'(w[i]);
      if (c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1) == 1) c = c + 8'd32;
      send_byte(side, c, 1'b0);
    end
  endtask

  task automatic send_data_burst(input logic side);
    int n;
    int r;
    int i;
    n = $urandom_range(1, 12);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 3);
      send_byte(side, (r == 0) ? CH_DLE : (r == 1) ? CH_ETX : 8'($urandom_range(0, 255)),
                1'b1);
    end
  endtask

  task automatic test_keyword_fold();
    send_text(1'b0, "ok", 1'b0);
    send_text(1'b1, "bUsY", 1'b0);
  endtask

  task automatic test_dle_etx();
    // On side A the ETX consumes the DLE; on side B a second ETX pairs again.
    send_byte(1'b0, CH_DLE, 1'b0);
    send_byte(1'b0, CH_ETX, 1'b0);
    send_byte(1'b0, CH_ETX, 1'b0);
    send_byte(1'b1, CH_DLE, 1'b1);
    send_byte(1'b1, CH_ETX, 1'b1);
    send_byte(1'b1, CH_ETX, 1'b1);
  endtask

  task automatic test_dle_stuffing();
    send_byte(1'b0, CH_DLE, 1'b1);
    send_byte(1'b0, CH_DLE, 1'b1);
    send_byte(1'b0, CH_DLE, 1'b1);
    send_byte(1'b0, CH_ETX, 1'b1);
    send_byte(1'b1, CH_DLE, 1'b0);
    send_byte(1'b1, CH_DLE, 1'b0);
    send_byte(1'b1, CH_ETX, 1'b0);
  endtask

  task automatic test_byte_extremes();
    send_byte(1'b0, 8'h00, 1'b0);
    send_byte(1'b1, 8'hff, 1'b1);
    send_byte(1'b0, 8'hff, 1'b0);
    send_byte(1'b1, 8'h00, 1'b1);
    // An 'O' with the top bit set must not start a match.
    send_byte(1'b1, 8'hcf, 1'b0);
    send_byte(1'b1, 8'h4b, 1'b0);
  endtask

  task automatic test_response_streams(input int target);
    logic side;
    int   i;
    while (sent_count < target) begin
      side = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          for (i = $urandom_range(0, 3); i > 0; i--) begin
            send_byte(side, ($urandom_range(0, 1) == 0) ? 8'h0d : 8'($urandom_range(0, 255)),
                      1'b0);
          end
          send_keyword(side, 1'b0);
        end
        6, 7: send_data_burst(side);
        8: begin
          send_byte(side, CH_DLE, 1'b0);
          send_byte(side, CH_ETX, 1'b0);
        end
        default: send_keyword(side, 1'b1);
      endcase
    end
  endtask

  task automatic test_noise(input int target);
    while (sent_count < target) begin
      if ($urandom_range(0, 3) == 0) send_keyword(1'($urandom_range(0, 1)), 1'b1);
      else send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_full_rate(input int target);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    test_response_streams(target);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    spot_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual event %0d data %02h",
                 $time, out_if.event_res, out_if.data_byte);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (out_if.event_res !== want.ev) begin
          $display("%0t: event mismatch, expected %0d, actual %0d",
                   $time, want.ev, out_if.event_res);
          errors++;
        end
        if (out_if.data_byte !== want.data) begin
          $display("%0t: data byte mismatch, expected %02h, actual %02h",
                   $time, want.data, out_if.data_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.side      = 1'b0;
    in_if.byte_in   = 8'h00;
    in_if.data_mode = 1'b0;
    out_if.ready    = 1'b0;
    for (int s = 0; s < 2; s++) begin
      last_byte[s] = 8'h00;
      for (int k = 0; k < 6; k++) match_pos[s][k] = 3'd0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_keyword_fold();
    test_dle_etx();
    test_dle_stuffing();
    test_byte_extremes();
    test_response_streams(1050);
    test_noise(1350);
    test_full_rate(1650);

    in_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
